/* rtl/core/modbus_tcp_reply_parser_unit_macros.svh */
// ----------------------------------------------------------------------------
// Modbus TCP reply parser assertion macros
// Clocked, reset-gated assertion wrappers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef MODBUS_TCP_REPLY_PARSER_UNIT_MACROS_SVH
`define MODBUS_TCP_REPLY_PARSER_UNIT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define MTRP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// expr must never be true outside reset
`define MTRP_ASSERT_NEVER(label, expr, msg) \
    `MTRP_ASSERT(label, !(expr), msg)

`endif

/* rtl/core/mtrp_pkg.sv */
// ----------------------------------------------------------------------------
// Modbus TCP reply parser package
// Shared types, item and status codes, function codes and frame offsets.
// ----------------------------------------------------------------------------
package mtrp_pkg;

    localparam int unsigned MTRP_OUT_DEPTH = 4;

    localparam logic [1:0] KIND_COIL    = 2'd0;
    localparam logic [1:0] KIND_REG     = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_COUNT = 2'd1;
    localparam logic [1:0] ST_FUNC  = 2'd2;
    localparam logic [1:0] ST_SHORT = 2'd3;

    localparam logic [7:0] FC_READ_COILS     = 8'd1;
    localparam logic [7:0] FC_READ_INPUTS    = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
    localparam logic [7:0] FC_READ_INPUT_REG = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
    localparam logic [7:0] FC_WRITE_REG      = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS    = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS     = 8'd16;

    localparam logic [7:0] COIL_ON = 8'hFF;

    // byte offsets within the reply
    localparam logic [8:0] POS_SEQ_HI  = 9'd0;
    localparam logic [8:0] POS_SEQ_LO  = 9'd1;
    localparam logic [8:0] POS_UNIT    = 9'd6;
    localparam logic [8:0] POS_FUNC    = 9'd7;
    localparam logic [8:0] POS_COUNT   = 9'd8;
    localparam logic [8:0] POS_ADDR_LO = 9'd9;
    localparam logic [8:0] POS_DATA    = 9'd9;
    localparam logic [8:0] POS_VAL_HI  = 9'd10;
    localparam logic [8:0] POS_VAL_LO  = 9'd11;
    localparam logic [8:0] POS_MAX     = 9'd511;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [15:0] data_value;
        logic [7:0]  element_index;
        logic [15:0] transaction_number;
        logic [7:0]  unit_address;
        logic [7:0]  reported_function;
        logic [1:0]  frame_status;
        logic [15:0] echo_address;
        logic [15:0] echo_value;
        logic        last_result;
    } mtrp_result_t;

    // up to two results per byte: data item first, summary second
    typedef struct packed {
        logic [1:0]   count;
        mtrp_result_t first;
        mtrp_result_t second;
    } mtrp_push_t;

endpackage

/* rtl/core/mtrp_in_if.sv */
// ----------------------------------------------------------------------------
// Reply byte stream interface
// Valid/ready channel carrying one reply byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface mtrp_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);

endinterface

/* rtl/core/mtrp_out_if.sv */
// ----------------------------------------------------------------------------
// Parser result stream interface
// Valid/ready channel carrying one data item or end-of-frame summary.
// ----------------------------------------------------------------------------
interface mtrp_out_if;

    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [15:0] data_value;
    logic [7:0]  element_index;
    logic [15:0] transaction_number;
    logic [7:0]  unit_address;
    logic [7:0]  reported_function;
    logic [1:0]  frame_status;
    logic [15:0] echo_address;
    logic [15:0] echo_value;
    logic        last_result;

    modport source (
        output valid, output item_kind, output data_value, output element_index,
        output transaction_number, output unit_address, output reported_function,
        output frame_status, output echo_address, output echo_value,
        output last_result, input ready
    );
    modport sink (
        input valid, input item_kind, input data_value, input element_index,
        input transaction_number, input unit_address, input reported_function,
        input frame_status, input echo_address, input echo_value,
        input last_result, output ready
    );

endinterface

/* rtl/core/modbus_tcp_reply_parser_unit.sv */
// ----------------------------------------------------------------------------
// Modbus TCP reply parser
// Splits a Modbus TCP reply byte stream into data items and a frame summary.
// ----------------------------------------------------------------------------
// Usage:
//   frame  : one reply byte per transfer, last_byte set on the final byte.
//   result : coil bytes (codes 1, 2), register values (codes 3, 4) and one
//            summary per frame with transaction, unit, function, status and
//            write echo fields; last_result marks the summary.
// Order: a result is presented the cycle after the byte transfer that
//   causes it, if no older result is queued. The final byte of a frame
//   can cause a data item and the summary; the data item leaves first.
// Throughput: one byte per cycle while ready is high. The parse state
//   updates in the cycle of the transfer; results go to an OUT_DEPTH
//   entry register queue, drained one per cycle while the receiver is ready.
// Stall: ready stays high while the queue has room for two results; a
//   stalled receiver lets the queue fill past that and ready then goes low.
// Reset: clears the parse state to the start of a frame and empties the
//   queue; the first byte can follow in the next cycle.
// ----------------------------------------------------------------------------
module modbus_tcp_reply_parser_unit #(
    parameter int unsigned OUT_DEPTH = mtrp_pkg::MTRP_OUT_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    mtrp_in_if.sink    frame,
    mtrp_out_if.source result
);
    import mtrp_pkg::*;

    mtrp_push_t push;
    logic       space_ok;

    mtrp_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame    (frame),
        .space_ok (space_ok),
        .push     (push)
    );

    mtrp_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space_ok (space_ok),
        .result   (result)
    );

endmodule

/* rtl/core/mtrp_parse.sv */
// ----------------------------------------------------------------------------
// Modbus TCP reply parser, byte stage
// Tracks frame position and header fields, forms data items and the summary.
// ----------------------------------------------------------------------------
`include "modbus_tcp_reply_parser_unit_macros.svh"

module mtrp_parse (
    input  logic               clk,
    input  logic               rst_n,
    mtrp_in_if.sink            frame,
    input  logic               space_ok,
    output mtrp_pkg::mtrp_push_t push
);
    import mtrp_pkg::*;

    logic [8:0]  pos_reg,   pos_next;
    logic [15:0] seq_reg,   seq_next;
    logic [7:0]  unit_reg,  unit_next;
    logic [7:0]  func_reg,  func_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  high_reg,  high_next;
    logic [15:0] addr_reg,  addr_next;
    logic [15:0] value_reg, value_next;
    logic [7:0]  elem_reg,  elem_next;

    logic         fire;
    logic [7:0]   b;
    logic         is_coil;
    logic         is_reg;
    logic         emit_data;
    logic [8:0]   data_len;
    logic [1:0]   status;
    logic [7:0]   func_out;
    logic [15:0]  echo_addr;
    logic [15:0]  echo_val;
    mtrp_result_t data_item;
    mtrp_result_t summary;

    assign frame.ready = space_ok;
    assign fire        = frame.valid && space_ok;
    assign b           = frame.in_byte;
    assign is_coil     = (func_reg == FC_READ_COILS) || (func_reg == FC_READ_INPUTS);
    assign is_reg      = (func_reg == FC_READ_HOLDING) || (func_reg == FC_READ_INPUT_REG);
    assign data_len    = pos_reg - POS_COUNT;

    always_comb
    begin
        seq_next   = seq_reg;
        unit_next  = unit_reg;
        func_next  = func_reg;
        count_next = count_reg;
        high_next  = high_reg;
        addr_next  = addr_reg;
        value_next = value_reg;
        case (pos_reg)
            POS_SEQ_HI:  seq_next = {b, 8'h00};
            POS_SEQ_LO:  seq_next = {seq_reg[15:8], b};
            POS_UNIT:    unit_next = b;
            POS_FUNC:    func_next = b;
            POS_COUNT:
            begin
                count_next = b;
                addr_next  = {b, 8'h00};
            end
            POS_ADDR_LO: addr_next  = {addr_reg[15:8], b};
            POS_VAL_HI:  value_next = {b, 8'h00};
            POS_VAL_LO:  value_next = {value_reg[15:8], b};
            default:     ;
        endcase

        emit_data = 1'b0;
        data_item = '0;
        if (pos_reg >= POS_DATA)
        begin
            if (is_coil)
            begin
                emit_data            = 1'b1;
                data_item.item_kind  = KIND_COIL;
                data_item.data_value = {8'h00, b};
            end
            else if (is_reg)
            begin
                // odd offsets start a register, even offsets complete it
                if (pos_reg[0])
                begin
                    high_next = b;
                end
                else if (pos_reg != POS_MAX)
                begin
                    emit_data            = 1'b1;
                    data_item.item_kind  = KIND_REG;
                    data_item.data_value = {high_reg, b};
                end
            end
        end
        data_item.element_index = elem_reg;
        elem_next = emit_data ? elem_reg + 8'd1 : elem_reg;
        pos_next  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 9'd1;

        status    = ST_OK;
        echo_addr = '0;
        echo_val  = '0;
        if (pos_reg < POS_FUNC)
        begin
            status = ST_SHORT;
        end
        else
        begin
            case (func_next) inside
                FC_READ_COILS, FC_READ_INPUTS, FC_READ_HOLDING, FC_READ_INPUT_REG:
                begin
                    if (pos_reg < POS_COUNT)
                        status = ST_SHORT;
                    else if ({1'b0, count_next} != data_len)
                        status = ST_COUNT;
                    else if ((func_next == FC_READ_HOLDING ||
                              func_next == FC_READ_INPUT_REG) && pos_reg[0])
                        status = ST_SHORT;
                end
                FC_WRITE_COIL:
                begin
                    if (pos_reg < POS_VAL_HI)
                    begin
                        status = ST_SHORT;
                    end
                    else
                    begin
                        echo_addr = addr_next;
                        echo_val  = (value_next[15:8] == COIL_ON) ? 16'd1 : 16'd0;
                    end
                end
                FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS:
                begin
                    if (pos_reg < POS_VAL_LO)
                    begin
                        status = ST_SHORT;
                    end
                    else
                    begin
                        echo_addr = addr_next;
                        echo_val  = value_next;
                    end
                end
                default: status = ST_FUNC;
            endcase
        end
        func_out = func_next;
        if (status != ST_OK)
        begin
            func_out  = '0;
            echo_addr = '0;
            echo_val  = '0;
        end

        summary                    = '0;
        summary.item_kind          = KIND_SUMMARY;
        summary.element_index      = elem_next;
        summary.transaction_number = seq_next;
        summary.unit_address       = unit_next;
        summary.reported_function  = func_out;
        summary.frame_status       = status;
        summary.echo_address       = echo_addr;
        summary.echo_value         = echo_val;
        summary.last_result        = 1'b1;

        push = '0;
        if (fire)
        begin
            if (emit_data)
            begin
                push.first  = data_item;
                push.second = summary;
                push.count  = frame.last_byte ? 2'd2 : 2'd1;
            end
            else if (frame.last_byte)
            begin
                push.first = summary;
                push.count = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            seq_reg   <= '0;
            unit_reg  <= '0;
            func_reg  <= '0;
            count_reg <= '0;
            high_reg  <= '0;
            addr_reg  <= '0;
            value_reg <= '0;
            elem_reg  <= '0;
        end
        else if (fire)
        begin
            if (frame.last_byte)
            begin
                pos_reg   <= '0;
                seq_reg   <= '0;
                unit_reg  <= '0;
                func_reg  <= '0;
                count_reg <= '0;
                high_reg  <= '0;
                addr_reg  <= '0;
                value_reg <= '0;
                elem_reg  <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                seq_reg   <= seq_next;
                unit_reg  <= unit_next;
                func_reg  <= func_next;
                count_reg <= count_next;
                high_reg  <= high_next;
                addr_reg  <= addr_next;
                value_reg <= value_next;
                elem_reg  <= elem_next;
            end
        end
    end

    `MTRP_ASSERT(a_frame_restart, fire && frame.last_byte |=> pos_reg == '0 && elem_reg == '0,
                 "parse state not cleared after final byte")
    `MTRP_ASSERT(a_pair_ends_frame, push.count == 2'd2 |->
                 push.second.item_kind == KIND_SUMMARY && push.first.item_kind != KIND_SUMMARY,
                 "two results without a trailing summary")
    `MTRP_ASSERT_NEVER(a_push_without_transfer, !fire && push.count != 2'd0,
                       "result pushed without an input transfer")

endmodule

/* rtl/core/mtrp_out_fifo.sv */
// ----------------------------------------------------------------------------
// Modbus TCP reply parser, result queue
// Register queue taking up to two results per cycle, one out per cycle if ready.
// ----------------------------------------------------------------------------
`include "modbus_tcp_reply_parser_unit_macros.svh"

module mtrp_out_fifo #(
    parameter int unsigned DEPTH = mtrp_pkg::MTRP_OUT_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mtrp_pkg::mtrp_push_t push,
    output logic                 space_ok,
    mtrp_out_if.source           result
);
    import mtrp_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mtrp_result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [PTR_W-1:0] wr_ptr_1;
    logic             pop;
    mtrp_result_t     head;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    assign wr_ptr_1 = ptr_inc(wr_ptr_reg);
    assign pop      = result.valid && result.ready;
    assign space_ok = count_reg <= CNT_W'(DEPTH - 2);

    always_comb
    begin
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head                      = mem[rd_ptr_reg];
    assign result.valid              = count_reg != '0;
    assign result.item_kind          = head.item_kind;
    assign result.data_value         = head.data_value;
    assign result.element_index      = head.element_index;
    assign result.transaction_number = head.transaction_number;
    assign result.unit_address       = head.unit_address;
    assign result.reported_function  = head.reported_function;
    assign result.frame_status       = head.frame_status;
    assign result.echo_address       = head.echo_address;
    assign result.echo_value         = head.echo_value;
    assign result.last_result        = head.last_result;

    `MTRP_ASSERT(a_no_overflow, count_reg <= CNT_W'(DEPTH), "result queue overflow")
    `MTRP_ASSERT(a_push_has_room, push.count != 2'd0 |-> space_ok,
                 "push while queue lacks room for two results")
    `MTRP_ASSERT(a_drain_empties,
                 count_reg == CNT_W'(1) && pop && push.count == 2'd0 |=> !result.valid,
                 "queue still valid after draining last entry")

endmodule
